// ----- rtl/core/ssfs_pkg.sv -----
package ssfs_pkg;

    localparam int SLOTS       = 16;
    localparam int HANDLE_BITS = 32;
    localparam int ITEM_W      = 32;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_FULL    = 2'd1,
        CAUSE_PRESENT = 2'd2,
        CAUSE_ABSENT  = 2'd3
    } t_cause;

    // Write port of the free-slot stack
    typedef struct packed {
        logic             push;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] slot;
    } t_stack_wr;

    // Keep the low HANDLE_BITS bits of an input handle, zero above bit ITEM_W-1
    function automatic logic [HANDLE_BITS-1:0] to_handle(input logic [ITEM_W-1:0] raw);
        logic [HANDLE_BITS-1:0] h;
        for (int b = 0; b < HANDLE_BITS; b++) begin
            h[b] = 1'(raw >> b);
        end
        return h;
    endfunction

endpackage

// ----- rtl/core/slot_set_with_free_stack_top.sv -----
// Slot set: one command a beat, handled one at a time.
// Steps: accept in ST_IDLE, handle compare in ST_SCAN (one slot per cycle
// through a single comparator), then update state and load the result in ST_DONE.
// A new command is taken only after ST_DONE; add-when-full and command 3 skip the compare.
// Reset (synchronous, i_rst_n low): all slots invalid, free stack holds 0..SLOTS-1,
// count zero, release disabled, no result pending.
module slot_set_with_free_stack_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [ssfs_pkg::ITEM_W-1:0]     i_item_handle,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_success,
    output logic [ssfs_pkg::IDX_W-1:0]      o_slot_number,
    output logic                            o_release_item,
    output logic [1:0]                      o_fail_cause,
    output logic [ssfs_pkg::CNT_W-1:0]      o_occupancy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                            r_state, n_state;
    ssfs_pkg::t_cmd                    r_cmd, n_cmd;
    logic [ssfs_pkg::HANDLE_BITS-1:0]  r_handle, n_handle;
    logic [ssfs_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic                              r_hit, n_hit;
    logic [ssfs_pkg::IDX_W-1:0]        r_hit_slot, n_hit_slot;
    logic [ssfs_pkg::SLOTS-1:0]        r_valid, n_valid;
    logic [ssfs_pkg::CNT_W-1:0]        r_count, n_count;
    logic                              r_release, n_release;
    logic                              r_out_valid, n_out_valid;
    logic                              r_success, n_success;
    logic [ssfs_pkg::IDX_W-1:0]        r_slot_num, n_slot_num;
    logic                              r_rel_item, n_rel_item;
    ssfs_pkg::t_cause                  r_cause, n_cause;
    logic [ssfs_pkg::CNT_W-1:0]        r_occ, n_occ;

    logic [ssfs_pkg::HANDLE_BITS-1:0]  r_slot_handle [ssfs_pkg::SLOTS];

    logic                              match;
    logic                              full;
    logic                              out_free;
    logic                              hw_en;
    logic [ssfs_pkg::IDX_W-1:0]        top_slot;
    logic [ssfs_pkg::CNT_W-1:0]        count_dec;
    ssfs_pkg::t_stack_wr               stack_wr;

    ssfs_free_stack u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_count[ssfs_pkg::IDX_W-1:0]),
        .i_wr      (stack_wr),
        .o_rd_slot (top_slot)
    );

    // The shared comparator: one slot per cycle
    assign match     = r_valid[r_idx] && (r_slot_handle[r_idx] == r_handle);
    assign full      = (r_count >= ssfs_pkg::CNT_W'(ssfs_pkg::SLOTS));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign count_dec = r_count - ssfs_pkg::CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_handle    = r_handle;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_valid     = r_valid;
        n_count     = r_count;
        n_release   = i_cfg_we ? i_cfg_wdata : r_release;
        n_out_valid = r_out_valid && i_out_stall;
        n_success   = r_success;
        n_slot_num  = r_slot_num;
        n_rel_item  = r_rel_item;
        n_cause     = r_cause;
        n_occ       = r_occ;
        hw_en       = 1'b0;
        stack_wr    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = ssfs_pkg::t_cmd'(i_command);
                    n_handle = ssfs_pkg::to_handle(i_item_handle);
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    // No lookup needed for a full add or the unused command
                    if (n_cmd == ssfs_pkg::CMD_NOP || (n_cmd == ssfs_pkg::CMD_ADD && full)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_idx;
                    n_state    = ST_DONE;
                end else if (r_idx == ssfs_pkg::IDX_W'(ssfs_pkg::SLOTS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + ssfs_pkg::IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_success   = 1'b0;
                    n_slot_num  = '0;
                    n_rel_item  = 1'b0;
                    n_cause     = ssfs_pkg::CAUSE_NONE;
                    unique case (r_cmd)
                        ssfs_pkg::CMD_ADD: begin
                            if (full) begin
                                n_cause = ssfs_pkg::CAUSE_FULL;
                            end else if (r_hit) begin
                                n_cause = ssfs_pkg::CAUSE_PRESENT;
                            end else begin
                                // Pop the top free slot
                                n_success         = 1'b1;
                                n_slot_num        = top_slot;
                                n_valid[top_slot] = 1'b1;
                                hw_en             = 1'b1;
                                n_count           = r_count + ssfs_pkg::CNT_W'(1);
                            end
                        end
                        ssfs_pkg::CMD_REMOVE: begin
                            if (r_hit) begin
                                // Push the freed slot back
                                n_success           = 1'b1;
                                n_slot_num          = r_hit_slot;
                                n_rel_item          = r_release;
                                n_valid[r_hit_slot] = 1'b0;
                                stack_wr.push       = 1'b1;
                                stack_wr.addr       = count_dec[ssfs_pkg::IDX_W-1:0];
                                stack_wr.slot       = r_hit_slot;
                                n_count             = count_dec;
                            end else begin
                                n_cause = ssfs_pkg::CAUSE_ABSENT;
                            end
                        end
                        ssfs_pkg::CMD_FIND: begin
                            if (r_hit) begin
                                n_success  = 1'b1;
                                n_slot_num = r_hit_slot;
                            end else begin
                                n_cause = ssfs_pkg::CAUSE_ABSENT;
                            end
                        end
                        ssfs_pkg::CMD_NOP: begin
                        end
                    endcase
                    n_occ   = n_count;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_release   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_release   <= n_release;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_handle   <= n_handle;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_success  <= n_success;
        r_slot_num <= n_slot_num;
        r_rel_item <= n_rel_item;
        r_cause    <= n_cause;
        r_occ      <= n_occ;
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            r_slot_handle[top_slot] <= r_handle;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_success      = r_success;
    assign o_slot_number  = r_slot_num;
    assign o_release_item = r_rel_item;
    assign o_fail_cause   = r_cause;
    assign o_occupancy    = r_occ;

endmodule

// ----- rtl/core/ssfs_free_stack.sv -----
module ssfs_free_stack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ssfs_pkg::IDX_W-1:0]     i_rd_addr,
    input  ssfs_pkg::t_stack_wr            i_wr,
    output logic [ssfs_pkg::IDX_W-1:0]     o_rd_slot
);

    logic [ssfs_pkg::IDX_W-1:0] r_stack [ssfs_pkg::SLOTS];

    // Reset fills entry i with slot i: all slots free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssfs_pkg::SLOTS; i++) begin
                r_stack[i] <= ssfs_pkg::IDX_W'(i);
            end
        end else if (i_wr.push) begin
            r_stack[i_wr.addr] <= i_wr.slot;
        end
    end

    assign o_rd_slot = r_stack[i_rd_addr];

endmodule
